/* src/bsfd_pkg.sv */
// Package for the byte stuffing frame decoder: constants, codes and shared types.
`timescale 1ns / 1ps
package bsfd_pkg;

  localparam int unsigned MAX_FRAME_DEF = 1024;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned IDX_W  = 3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_ESCAPE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW   = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_HEAD_HIGH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEAD_LOW    = 3'd1;
  localparam logic [IDX_W-1:0] REG_TAIL_HIGH   = 3'd2;
  localparam logic [IDX_W-1:0] REG_TAIL_LOW    = 3'd3;
  localparam logic [IDX_W-1:0] REG_ESCAPE_CHAR = 3'd4;
  localparam logic [IDX_W-1:0] REG_FILLER_BYTE = 3'd5;

  // Register reset values
  localparam logic [BYTE_W-1:0] RST_HEAD_HIGH   = 8'h55;
  localparam logic [BYTE_W-1:0] RST_HEAD_LOW    = 8'hAA;
  localparam logic [BYTE_W-1:0] RST_TAIL_HIGH   = 8'h0A;
  localparam logic [BYTE_W-1:0] RST_TAIL_LOW    = 8'h0D;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_CHAR = 8'h7F;
  localparam logic [BYTE_W-1:0] RST_FILLER_BYTE = 8'hFF;

  typedef struct packed {
    logic [BYTE_W-1:0] head_high;
    logic [BYTE_W-1:0] head_low;
    logic [BYTE_W-1:0] tail_high;
    logic [BYTE_W-1:0] tail_low;
    logic [BYTE_W-1:0] escape_char;
    logic [BYTE_W-1:0] filler_byte;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage

/* src/bsfd_cfg_regs.sv */
// Configuration register file of the byte stuffing frame decoder.
`timescale 1ns / 1ps
module bsfd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bsfd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [bsfd_pkg::BYTE_W-1:0]    cfg_data,
  output bsfd_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_high   <= bsfd_pkg::RST_HEAD_HIGH;
      cfg.head_low    <= bsfd_pkg::RST_HEAD_LOW;
      cfg.tail_high   <= bsfd_pkg::RST_TAIL_HIGH;
      cfg.tail_low    <= bsfd_pkg::RST_TAIL_LOW;
      cfg.escape_char <= bsfd_pkg::RST_ESCAPE_CHAR;
      cfg.filler_byte <= bsfd_pkg::RST_FILLER_BYTE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsfd_pkg::REG_HEAD_HIGH:   cfg.head_high   <= cfg_data;
        bsfd_pkg::REG_HEAD_LOW:    cfg.head_low    <= cfg_data;
        bsfd_pkg::REG_TAIL_HIGH:   cfg.tail_high   <= cfg_data;
        bsfd_pkg::REG_TAIL_LOW:    cfg.tail_low    <= cfg_data;
        bsfd_pkg::REG_ESCAPE_CHAR: cfg.escape_char <= cfg_data;
        bsfd_pkg::REG_FILLER_BYTE: cfg.filler_byte <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

endmodule

/* src/bsfd_decode.sv */
// Deframing state and per-byte decode logic of the byte stuffing frame decoder.
`timescale 1ns / 1ps
module bsfd_decode #(
  parameter int unsigned MAX_FRAME = bsfd_pkg::MAX_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [bsfd_pkg::BYTE_W-1:0]   rx_byte,
  input  bsfd_pkg::cfg_t                cfg,
  output bsfd_pkg::result_t             res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
  localparam int unsigned LEN_W = bsfd_pkg::LEN_W;
  localparam int unsigned BYTE_W = bsfd_pkg::BYTE_W;

  localparam logic [BYTE_W-1:0] ESC_DEL       = 8'h01;
  localparam logic [BYTE_W-1:0] ESC_HEAD_HIGH = 8'h02;
  localparam logic [BYTE_W-1:0] ESC_HEAD_LOW  = 8'h03;
  localparam logic [BYTE_W-1:0] ESC_TAIL_HIGH = 8'h04;
  localparam logic [BYTE_W-1:0] ESC_TAIL_LOW  = 8'h05;
  localparam logic [BYTE_W-1:0] ESC_FILLER    = 8'h06;
  localparam logic [BYTE_W-1:0] DEL_BYTE      = 8'h7F;

  logic             in_frame, in_frame_next;
  logic             saw_head_high, saw_head_high_next;
  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] payload_count, payload_count_next;

  logic                      pay_go;
  logic [BYTE_W-1:0]         pay_byte;
  logic [CNT_W+LEN_W-1:0]    count_ext;

  // Report the count modulo the length field's range.
  assign count_ext = {{LEN_W{1'b0}}, payload_count};

  always_comb begin
    in_frame_next       = in_frame;
    saw_head_high_next  = saw_head_high;
    escape_pending_next = escape_pending;
    payload_count_next  = payload_count;
    res                 = '0;
    res.kind            = bsfd_pkg::KIND_PAYLOAD;
    pay_go              = 1'b0;
    pay_byte            = '0;

    if (take && rx_byte != cfg.filler_byte) begin
      if (!in_frame) begin
        if (saw_head_high && rx_byte == cfg.head_low) begin
          in_frame_next       = 1'b1;
          saw_head_high_next  = 1'b0;
          escape_pending_next = 1'b0;
          payload_count_next  = '0;
        end else begin
          saw_head_high_next = (rx_byte == cfg.head_high);
        end
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        pay_go              = 1'b1;
        unique case (rx_byte)
          ESC_DEL:       pay_byte = DEL_BYTE;
          ESC_HEAD_HIGH: pay_byte = cfg.head_high;
          ESC_HEAD_LOW:  pay_byte = cfg.head_low;
          ESC_TAIL_HIGH: pay_byte = cfg.tail_high;
          ESC_TAIL_LOW:  pay_byte = cfg.tail_low;
          ESC_FILLER:    pay_byte = cfg.filler_byte;
          default: begin
            pay_go             = 1'b0;
            in_frame_next      = 1'b0;
            saw_head_high_next = 1'b0;
            payload_count_next = '0;
            res.valid          = 1'b1;
            res.kind           = bsfd_pkg::KIND_BAD_ESCAPE;
          end
        endcase
      end else if (rx_byte == cfg.escape_char) begin
        escape_pending_next = 1'b1;
      end else if (rx_byte == cfg.tail_high) begin
        in_frame_next      = 1'b0;
        saw_head_high_next = 1'b0;
        payload_count_next = '0;
        res.valid          = 1'b1;
        res.kind           = bsfd_pkg::KIND_DONE;
        res.frame_length   = count_ext[LEN_W-1:0];
      end else begin
        pay_go   = 1'b1;
        pay_byte = rx_byte;
      end
    end

    if (pay_go) begin
      res.valid = 1'b1;
      if (payload_count >= CNT_W'(MAX_FRAME)) begin
        // Frame too long: drop the byte and hunt again.
        in_frame_next       = 1'b0;
        saw_head_high_next  = 1'b0;
        escape_pending_next = 1'b0;
        payload_count_next  = '0;
        res.kind            = bsfd_pkg::KIND_OVERFLOW;
      end else begin
        payload_count_next = payload_count + CNT_W'(1);
        res.kind           = bsfd_pkg::KIND_PAYLOAD;
        res.payload        = pay_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      saw_head_high  <= 1'b0;
      escape_pending <= 1'b0;
      payload_count  <= '0;
    end else begin
      in_frame       <= in_frame_next;
      saw_head_high  <= saw_head_high_next;
      escape_pending <= escape_pending_next;
      payload_count  <= payload_count_next;
    end
  end

endmodule

/* src/bsfd_out_reg.sv */
// Result register of the byte stuffing frame decoder, with stream handshake.
`timescale 1ns / 1ps
module bsfd_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  bsfd_pkg::result_t             res,
  output logic                          room,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output bsfd_pkg::result_t             held
);

  // Space for a new result whenever the register is empty or being drained.
  assign room     = !held.valid || m_tready;
  assign m_tvalid = held.valid;

  always_ff @(posedge clk) begin
    if (room && res.valid) begin
      held.kind         <= res.kind;
      held.payload      <= res.payload;
      held.frame_length <= res.frame_length;
    end
    if (rst) begin
      held.valid <= 1'b0;
    end else if (room) begin
      held.valid <= res.valid;
    end
  end

endmodule

/* src/byte_stuffing_frame_decoder_core.sv */
// Top level of the byte stuffing frame decoder.
//
//   channel  dir  handshake            contents
//   s_       in   s_tvalid/s_tready    s_tdata[7:0] rx_byte
//   m_       out  m_tvalid/m_tready    m_tuser[1:0] kind, m_tdata[7:0] payload,
//                                      m_tdata[18:8] frame_length, rest zero
//   cfg_     in   cfg_we (no wait)     cfg_index selects register, cfg_data value
//
// One received word is taken per cycle while s_tready is high. Its decode runs
// in the same cycle in the deframing logic and lands in the result register, so
// a result shows on the master side in the cycle after its word is taken. s_tready
// follows the result register: high when it is empty or drained in this cycle.
// Filler bytes, header bytes and escape introducers give no result. rst is
// synchronous and returns the block to header hunting with reset registers.
`timescale 1ns / 1ps
module byte_stuffing_frame_decoder_core #(
  parameter int unsigned MAX_FRAME = bsfd_pkg::MAX_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave side: [7:0] rx_byte
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,
  // master side
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,  // [7:0] payload, [18:8] frame_length
  output logic [1:0]                    m_tuser,  // [1:0] kind
  // configuration write port
  input  logic                          cfg_we,
  input  logic [bsfd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bsfd_pkg::BYTE_W-1:0]   cfg_data
);

  bsfd_pkg::cfg_t    cfg;
  bsfd_pkg::result_t res;
  bsfd_pkg::result_t held;
  logic              room;
  logic              take;

  // Hold the line registers.
  bsfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the deframer on every taken word.
  assign s_tready = room;
  assign take     = s_tvalid && room;

  bsfd_decode #(
    .MAX_FRAME (MAX_FRAME)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (s_tdata),
    .cfg     (cfg),
    .res     (res)
  );

  bsfd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .held     (held)
  );

  // Pack the result word; pad to whole bytes with zeros.
  assign m_tdata = {5'd0, held.frame_length, held.payload};
  assign m_tuser = held.kind;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the byte stuffing frame decoder core.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned CYCLE_LIMIT = 600000;

  // Escape codes and the fixed byte that code one restores
  localparam logic [7:0] CODE_DEL       = 8'h01;
  localparam logic [7:0] CODE_HEAD_HIGH = 8'h02;
  localparam logic [7:0] CODE_HEAD_LOW  = 8'h03;
  localparam logic [7:0] CODE_TAIL_HIGH = 8'h04;
  localparam logic [7:0] CODE_TAIL_LOW  = 8'h05;
  localparam logic [7:0] CODE_FILLER    = 8'h06;
  localparam logic [7:0] DEL_BYTE       = 8'h7F;

  // Indexes with no register behind them
  localparam logic [bsfd_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bsfd_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [bsfd_pkg::KIND_W-1:0] kind;
    logic [bsfd_pkg::BYTE_W-1:0] payload;
    logic [bsfd_pkg::LEN_W-1:0]  flen;
  } deframe_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [7:0]                  s_tdata = 8'h00;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [23:0]                 m_tdata;
  logic [1:0]                  m_tuser;
  logic                        cfg_we = 1'b0;
  logic [bsfd_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [bsfd_pkg::BYTE_W-1:0] cfg_data = '0;

  byte_stuffing_frame_decoder_core #(
    .MAX_FRAME(bsfd_pkg::MAX_FRAME_DEF)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Line bytes waiting to be offered, and decoded results still owed by the block
  logic [7:0]      line_bytes[$];
  deframe_result_t expected_results[$];

  // Shadow of the register file and of the deframing state
  bsfd_pkg::cfg_t shadow = '{head_high: bsfd_pkg::RST_HEAD_HIGH,
                             head_low: bsfd_pkg::RST_HEAD_LOW,
                             tail_high: bsfd_pkg::RST_TAIL_HIGH,
                             tail_low: bsfd_pkg::RST_TAIL_LOW,
                             escape_char: bsfd_pkg::RST_ESCAPE_CHAR,
                             filler_byte: bsfd_pkg::RST_FILLER_BYTE};
  bit          in_frame = 1'b0;
  bit          saw_head_high = 1'b0;
  bit          escape_pending = 1'b0;
  int unsigned payload_count = 0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned phase_items = 0;
  bit          word_taken = 1'b0;
  bit          hold_ask = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor: decode one accepted line byte into zero or one expected result
  // ---------------------------------------------------------------------------
  task automatic owe_result(input logic [bsfd_pkg::KIND_W-1:0] kind,
                            input logic [7:0] data, input int unsigned len);
    deframe_result_t r;
    r.kind    = kind;
    r.payload = data;
    r.flen    = len[bsfd_pkg::LEN_W-1:0];
    expected_results.push_back(r);
  endtask

  task automatic drop_to_hunt();
    in_frame       = 1'b0;
    saw_head_high  = 1'b0;
    escape_pending = 1'b0;
    payload_count  = 0;
  endtask

  task automatic emit_or_overflow(input logic [7:0] data);
    if (payload_count >= bsfd_pkg::MAX_FRAME_DEF) begin
      drop_to_hunt();
      owe_result(bsfd_pkg::KIND_OVERFLOW, 8'h00, 0);
    end else begin
      payload_count++;
      owe_result(bsfd_pkg::KIND_PAYLOAD, data, 0);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0]  restored;
    bit          code_ok;
    int unsigned len;
    // filler vanishes before any other test
    if (b == shadow.filler_byte) return;
    if (!in_frame) begin
      if (saw_head_high && b == shadow.head_low) begin
        in_frame       = 1'b1;
        saw_head_high  = 1'b0;
        escape_pending = 1'b0;
        payload_count  = 0;
      end else begin
        saw_head_high = (b == shadow.head_high);
      end
      return;
    end
    if (escape_pending) begin
      escape_pending = 1'b0;
      code_ok = 1'b1;
      restored = 8'h00;
      case (b)
        CODE_DEL:       restored = DEL_BYTE;
        CODE_HEAD_HIGH: restored = shadow.head_high;
        CODE_HEAD_LOW:  restored = shadow.head_low;
        CODE_TAIL_HIGH: restored = shadow.tail_high;
        CODE_TAIL_LOW:  restored = shadow.tail_low;
        CODE_FILLER:    restored = shadow.filler_byte;
        default:        code_ok = 1'b0;
      endcase
      if (code_ok) begin
        emit_or_overflow(restored);
      end else begin
        // a bad code never arms the header search
        drop_to_hunt();
        owe_result(bsfd_pkg::KIND_BAD_ESCAPE, 8'h00, 0);
      end
      return;
    end
    // escape wins over tail when both registers hold the same byte
    if (b == shadow.escape_char) begin
      escape_pending = 1'b1;
    end else if (b == shadow.tail_high) begin
      len = payload_count;
      drop_to_hunt();
      owe_result(bsfd_pkg::KIND_DONE, 8'h00, len);
    end else begin
      emit_or_overflow(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, a few long ones, and now and then a calm stretch with none
  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] code_for(input logic [7:0] v);
    if (v == DEL_BYTE) return CODE_DEL;
    if (v == shadow.head_high) return CODE_HEAD_HIGH;
    if (v == shadow.head_low) return CODE_HEAD_LOW;
    if (v == shadow.tail_high) return CODE_TAIL_HIGH;
    if (v == shadow.tail_low) return CODE_TAIL_LOW;
    if (v == shadow.filler_byte) return CODE_FILLER;
    return 8'h00;
  endfunction

  // Queue one line byte, sometimes with a filler byte slipped in ahead of it
  task automatic put_byte(input logic [7:0] b);
    if ($urandom_range(0, 15) == 0) line_bytes.push_back(shadow.filler_byte);
    line_bytes.push_back(b);
    phase_items++;
  endtask

  task automatic put_payload(input logic [7:0] v);
    logic [7:0] c;
    c = code_for(v);
    if (v == shadow.escape_char || v == shadow.tail_high || v == shadow.filler_byte) begin
      // a byte the line cannot carry bare; with no code for it, send any valid code
      if (c == 8'h00) c = 8'($urandom_range(CODE_DEL, CODE_FILLER));
      put_byte(shadow.escape_char);
      put_byte(c);
    end else if (c != 8'h00 && $urandom_range(0, 7) == 0) begin
      put_byte(shadow.escape_char);
      put_byte(c);
    end else begin
      put_byte(v);
    end
  endtask

  function automatic logic [7:0] pick_content();
    case ($urandom_range(0, 11))
      0:       return shadow.head_high;
      1:       return shadow.head_low;
      2:       return shadow.tail_high;
      3:       return shadow.escape_char;
      4:       return shadow.filler_byte;
      5:       return DEL_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_frame(input int unsigned len);
    if ($urandom_range(0, 5) == 0) put_byte(shadow.head_high);
    put_byte(shadow.head_high);
    put_byte(shadow.head_low);
    repeat (len) put_payload(pick_content());
    put_byte(shadow.tail_high);
    if ($urandom_range(0, 3) != 0) put_byte(shadow.tail_low);
  endtask

  task automatic put_random_chunk();
    int unsigned r;
    logic [7:0]  bad;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      put_frame(($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 48));
    end else if (r < 80) begin
      // broken frame: a bad escape code, or a frame cut off before its tail
      put_byte(shadow.head_high);
      put_byte(shadow.head_low);
      repeat ($urandom_range(0, 6)) put_payload(pick_content());
      if ($urandom_range(0, 1) == 0) begin
        do bad = 8'($urandom_range(0, 255));
        while (bad >= CODE_DEL && bad <= CODE_FILLER);
        put_byte(shadow.escape_char);
        put_byte(bad);
      end
    end else begin
      repeat ($urandom_range(1, 8)) put_byte(($urandom_range(0, 3) == 0) ? pick_content()
                                                          : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_random(input int unsigned budget);
    phase_items = 0;
    while (phase_items < budget) put_random_chunk();
  endtask

  task automatic write_reg(input logic [bsfd_pkg::IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      bsfd_pkg::REG_HEAD_HIGH:   shadow.head_high   = val;
      bsfd_pkg::REG_HEAD_LOW:    shadow.head_low    = val;
      bsfd_pkg::REG_TAIL_HIGH:   shadow.tail_high   = val;
      bsfd_pkg::REG_TAIL_LOW:    shadow.tail_low    = val;
      bsfd_pkg::REG_ESCAPE_CHAR: shadow.escape_char = val;
      bsfd_pkg::REG_FILLER_BYTE: shadow.filler_byte = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] hh, input logic [7:0] hl, input logic [7:0] th,
                           input logic [7:0] tl, input logic [7:0] esc, input logic [7:0] fill);
    write_reg(bsfd_pkg::REG_HEAD_HIGH, hh);
    write_reg(bsfd_pkg::REG_HEAD_LOW, hl);
    write_reg(bsfd_pkg::REG_TAIL_HIGH, th);
    write_reg(bsfd_pkg::REG_TAIL_LOW, tl);
    write_reg(bsfd_pkg::REG_ESCAPE_CHAR, esc);
    write_reg(bsfd_pkg::REG_FILLER_BYTE, fill);
  endtask

  // Wait until every byte is taken and every result is back, then let the
  // last byte's decode settle before anything touches the registers
  task automatic drain();
    while (line_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer: fill the byte queue phase by phase, reconfigure only when idle
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] opening[$];
    logic [7:0] esc_tail[$];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset registers. Filler between and around header bytes, overlapping
    // header search, every escape code, a done, the tail low byte ignored
    // while hunting, then a bad code that must not arm the header search.
    opening = '{bsfd_pkg::RST_FILLER_BYTE, bsfd_pkg::RST_HEAD_HIGH,
                bsfd_pkg::RST_FILLER_BYTE, bsfd_pkg::RST_HEAD_HIGH,
                bsfd_pkg::RST_HEAD_LOW,
                bsfd_pkg::RST_ESCAPE_CHAR, bsfd_pkg::RST_FILLER_BYTE, CODE_DEL,
                bsfd_pkg::RST_ESCAPE_CHAR, CODE_HEAD_HIGH,
                bsfd_pkg::RST_ESCAPE_CHAR, CODE_HEAD_LOW,
                bsfd_pkg::RST_ESCAPE_CHAR, CODE_TAIL_HIGH,
                bsfd_pkg::RST_ESCAPE_CHAR, CODE_TAIL_LOW,
                bsfd_pkg::RST_ESCAPE_CHAR, CODE_FILLER,
                8'h00, bsfd_pkg::RST_TAIL_HIGH, bsfd_pkg::RST_TAIL_LOW,
                bsfd_pkg::RST_HEAD_HIGH, bsfd_pkg::RST_HEAD_LOW,
                bsfd_pkg::RST_ESCAPE_CHAR, bsfd_pkg::RST_HEAD_HIGH,
                bsfd_pkg::RST_HEAD_LOW, bsfd_pkg::RST_TAIL_HIGH};
    foreach (opening[i]) line_bytes.push_back(opening[i]);

    // One frame past the maximum length, to reach the overflow
    put_frame(bsfd_pkg::MAX_FRAME_DEF + $urandom_range(1, 4));
    @(posedge clk);
    hold_ask = 1'b1;
    put_random(80);
    drain();

    // Extremes, with the unused indexes written too
    write_all(8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h7F);
    write_reg(REG_SPARE_LO, 8'h00);
    write_reg(REG_SPARE_HI, 8'hFF);
    put_random(60);
    drain();

    // Escape byte equal to tail high: frames can only end in an error
    write_all(8'hAA, 8'h55, 8'h1B, 8'h0D, 8'h1B, 8'h00);
    esc_tail = '{8'hAA, 8'h55, 8'h1B, CODE_TAIL_HIGH, 8'h41, 8'h1B, 8'h09};
    foreach (esc_tail[i]) line_bytes.push_back(esc_tail[i]);
    put_random(60);
    drain();

    // Both header bytes the same
    write_all(8'h33, 8'h33, 8'hFF, 8'h00, 8'h7F, 8'hC0);
    put_random(60);
    drain();

    write_all(bsfd_pkg::RST_HEAD_HIGH, bsfd_pkg::RST_HEAD_LOW, bsfd_pkg::RST_TAIL_HIGH,
              bsfd_pkg::RST_TAIL_LOW, bsfd_pkg::RST_ESCAPE_CHAR, bsfd_pkg::RST_FILLER_BYTE);
    put_random(40);
    drain();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: offer queued bytes, hold a word until it is taken
  // ---------------------------------------------------------------------------
  int unsigned src_wait = 0;
  int unsigned src_calm = 0;

  always @(negedge clk) begin : sender
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = s_tvalid;
    nxt_data  = s_tdata;
    if (!rst && (!s_tvalid || word_taken)) begin
      nxt_valid = 1'b0;
      if (src_wait > 0) begin
        src_wait--;
      end else if (line_bytes.size() != 0) begin
        nxt_valid = 1'b1;
        nxt_data  = line_bytes.pop_front();
        src_wait  = draw_gap(src_calm);
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata  <= nxt_data;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off that backs up the block
  // ---------------------------------------------------------------------------
  int unsigned sink_wait = 0;
  int unsigned sink_calm = 0;
  int unsigned hold_left = 0;

  always @(negedge clk) begin
    if (hold_ask) begin
      hold_left = 400;
      hold_ask  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready  <= 1'b1;
      sink_wait = draw_gap(sink_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result word against the oldest expectation, then
  // predict from the word taken at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    deframe_result_t got;
    deframe_result_t want;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      cycles++;
      word_taken = 1'b0;
      if (!rst) begin
        if (m_tvalid && m_tready) begin
          got.kind    = m_tuser;
          got.payload = m_tdata[7:0];
          got.flen    = m_tdata[18:8];
          if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, got kind %0d payload %02h len %0d",
                     $time, got.kind, got.payload, got.flen);
          end else begin
            want = expected_results.pop_front();
            if (got.kind != want.kind) begin
              errors++;
              $display("%0t: kind mismatch, expected %0d, got %0d",
                       $time, want.kind, got.kind);
            end
            if (got.payload != want.payload) begin
              errors++;
              $display("%0t: payload mismatch, expected %02h, got %02h",
                       $time, want.payload, got.payload);
            end
            if (got.flen != want.flen) begin
              errors++;
              $display("%0t: frame_length mismatch, expected %0d, got %0d",
                       $time, want.flen, got.flen);
            end
          end
        end
        word_taken = s_tvalid && s_tready;
        if (word_taken) deframe_byte(s_tdata);
      end
    end
  end

endmodule
